>>> rtl/dpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the demand paging table
// Transfer payloads, table entry and per-process counter words, update flags.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int NUM_PROCESSES_DEF     = 32;
    localparam int PAGES_PER_PROCESS_DEF = 64;
    localparam int NUM_FRAMES_DEF        = 256;

    localparam logic [7:0]  REFS_MAX         = 8'd255;
    localparam logic [7:0]  PFAULT_MAX       = 8'd255;
    localparam logic [8:0]  SFAULT_MAX       = 9'd511;
    localparam logic [15:0] COUNT16_MAX      = 16'hFFFF;
    localparam logic [8:0]  FIRST_FREE_RESET = 9'd8;

    typedef struct packed {
        logic [4:0] process_id;
        logic [5:0] virtual_page;
    } dpt_req_t;

    typedef struct packed {
        logic [7:0]  frame_number;
        logic        page_fault;
        logic        out_of_memory;
        logic [7:0]  page_ref_count;
        logic [7:0]  process_fault_count;
        logic [15:0] process_reference_count;
        logic [8:0]  total_fault_count;
        logic [15:0] total_reference_count;
    } dpt_rsp_t;

    // One page table entry
    typedef struct packed {
        logic       valid;
        logic [7:0] frame;
        logic [7:0] refs;
    } dpt_entry_t;

    // Per-process counters
    typedef struct packed {
        logic [7:0]  faults;
        logic [15:0] refs;
    } dpt_pcnt_t;

    // What one reference commits to state
    typedef struct packed {
        logic commit_entry;
        logic commit_proc;
        logic take_frame;
        logic set_oom;
    } dpt_upd_t;

endpackage

>>> rtl/demand_paging_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_table: per-process page table with demand frame allocation
// Translate (process, page) references, allocate frames on faults, keep
// per-entry, per-process and global reference and fault counters.
// ----------------------------------------------------------------------------
//
//  channel   | signals                     | direction | payload
//  ----------+-----------------------------+-----------+-------------------
//  req       | req_valid / req_ready / req | in        | dpt_req_t
//  rsp       | rsp_valid / rsp_ready / rsp | out       | dpt_rsp_t
//  cfg       | cfg_we / cfg_wdata          | in        | first_free_frame
//
//  One reference per cycle; a stalled response holds the update stage and, once
//  it is occupied, req_ready low. The table read is issued at the transfer; the
//  write back and the response register load as the update stage advances. A
//  one-deep forwarding register covers a back-to-back reference to the same
//  entry. After reset a clearing pass writes every entry, one per cycle
//  (NUM_PROCESSES * PAGES_PER_PROCESS, 2048 at defaults) with req_ready low.
//
module demand_paging_table #(
    parameter int NUM_PROCESSES     = dpt_pkg::NUM_PROCESSES_DEF,
    parameter int PAGES_PER_PROCESS = dpt_pkg::PAGES_PER_PROCESS_DEF,
    parameter int NUM_FRAMES        = dpt_pkg::NUM_FRAMES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dpt_pkg::dpt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dpt_pkg::dpt_rsp_t rsp,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_wdata
);
    import dpt_pkg::*;

    localparam int TABLE_DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int PID_AW      = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int ENTRY_W     = $bits(dpt_entry_t);
    localparam int PCNT_W      = $bits(dpt_pcnt_t);

    // Clearing sequencer
    logic              clr_busy;
    logic [TBL_AW-1:0] clr_addr;

    // Request decode
    logic              req_xfer;
    logic              req_in_range;
    logic [13:0]       req_idx_full;
    logic [TBL_AW-1:0] req_idx;
    logic [PID_AW-1:0] req_pid;

    // Update stage
    logic              s1_vld_reg;
    logic              s1_inr_reg;
    logic [TBL_AW-1:0] s1_addr_reg;
    logic [PID_AW-1:0] s1_pid_reg;
    logic              s1_adv;

    // Memories and forwarding
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [PCNT_W-1:0]  proc_rdata;
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr;
    dpt_entry_t         tbl_wdata;
    logic               proc_we;
    logic [PID_AW-1:0]  proc_waddr;
    dpt_pcnt_t          proc_wdata;

    logic               tfwd_vld_reg;
    logic [TBL_AW-1:0]  tfwd_addr_reg;
    dpt_entry_t         tfwd_data_reg;
    logic               pfwd_vld_reg;
    logic [PID_AW-1:0]  pfwd_addr_reg;
    dpt_pcnt_t          pfwd_data_reg;

    dpt_entry_t         entry_cur;
    dpt_pcnt_t          pcnt_cur;

    // Global state
    logic [8:0]  next_frame_reg;
    logic [8:0]  sum_faults_reg;
    logic [15:0] sum_refs_reg;
    logic        oom_reg;

    // Update results
    dpt_entry_t  entry_new;
    dpt_pcnt_t   pcnt_new;
    dpt_upd_t    upd;
    logic [8:0]  sum_faults_new;
    logic [15:0] sum_refs_new;
    dpt_rsp_t    rsp_new;

    // Output register
    logic        rsp_vld_reg;
    dpt_rsp_t    rsp_reg;

    dpt_clear #(
        .DEPTH (TABLE_DEPTH)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    // ---------------------------------------------------------------------
    // Request side: accept when clearing is done and the update stage frees
    // ---------------------------------------------------------------------
    assign s1_adv    = s1_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !clr_busy && (!s1_vld_reg || s1_adv);
    assign req_xfer  = req_valid && req_ready;

    assign req_in_range = (6'(req.process_id) < 6'(NUM_PROCESSES))
                       && (9'(req.virtual_page) < 9'(PAGES_PER_PROCESS));
    assign req_idx_full = 14'(req.process_id) * 14'(PAGES_PER_PROCESS)
                        + 14'(req.virtual_page);
    assign req_idx      = req_idx_full[TBL_AW-1:0];
    assign req_pid      = req.process_id[PID_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (req_xfer)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_inr_reg  <= req_in_range;
            s1_addr_reg <= req_idx;
            s1_pid_reg  <= req_pid;
        end
    end

    // ---------------------------------------------------------------------
    // Memories: the clearing pass owns the write ports until it finishes
    // ---------------------------------------------------------------------
    assign tbl_we     = clr_busy || (s1_adv && upd.commit_entry);
    assign tbl_waddr  = clr_busy ? clr_addr : s1_addr_reg;
    assign tbl_wdata  = clr_busy ? dpt_entry_t'('0) : entry_new;

    assign proc_we    = (clr_busy && (clr_addr < TBL_AW'(NUM_PROCESSES)))
                     || (s1_adv && upd.commit_proc);
    assign proc_waddr = clr_busy ? clr_addr[PID_AW-1:0] : s1_pid_reg;
    assign proc_wdata = clr_busy ? dpt_pcnt_t'('0) : pcnt_new;

    dpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (req_xfer),
        .raddr (req_idx),
        .rdata (tbl_rdata)
    );

    dpt_ram #(
        .WIDTH (PCNT_W),
        .DEPTH (NUM_PROCESSES)
    ) u_proc_ram (
        .clk   (clk),
        .we    (proc_we),
        .waddr (proc_waddr),
        .wdata (proc_wdata),
        .re    (req_xfer),
        .raddr (req_pid),
        .rdata (proc_rdata)
    );

    // Hold the most recent commit; it is always the newest copy of its entry,
    // so it overrides a read that was issued on the same edge as that write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tfwd_vld_reg <= 1'b0;
            pfwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && upd.commit_entry)
            begin
                tfwd_vld_reg <= 1'b1;
            end
            if (s1_adv && upd.commit_proc)
            begin
                pfwd_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && upd.commit_entry)
        begin
            tfwd_addr_reg <= s1_addr_reg;
            tfwd_data_reg <= entry_new;
        end
        if (s1_adv && upd.commit_proc)
        begin
            pfwd_addr_reg <= s1_pid_reg;
            pfwd_data_reg <= pcnt_new;
        end
    end

    assign entry_cur = (tfwd_vld_reg && (tfwd_addr_reg == s1_addr_reg))
                     ? tfwd_data_reg : dpt_entry_t'(tbl_rdata);
    assign pcnt_cur  = (pfwd_vld_reg && (pfwd_addr_reg == s1_pid_reg))
                     ? pfwd_data_reg : dpt_pcnt_t'(proc_rdata);

    // ---------------------------------------------------------------------
    // Update
    // ---------------------------------------------------------------------
    dpt_update #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_update (
        .in_range       (s1_inr_reg),
        .entry          (entry_cur),
        .pcnt           (pcnt_cur),
        .next_frame     (next_frame_reg),
        .exhausted      (oom_reg),
        .sum_faults     (sum_faults_reg),
        .sum_refs       (sum_refs_reg),
        .entry_new      (entry_new),
        .pcnt_new       (pcnt_new),
        .upd            (upd),
        .sum_faults_new (sum_faults_new),
        .sum_refs_new   (sum_refs_new),
        .rsp            (rsp_new)
    );

    // Global counters, bump allocator and the sticky exhaustion flag.
    // A configuration write reloads the allocator and nothing else.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_frame_reg <= FIRST_FREE_RESET;
            sum_faults_reg <= '0;
            sum_refs_reg   <= '0;
            oom_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                next_frame_reg <= cfg_wdata;
            end
            else if (s1_adv && upd.take_frame)
            begin
                next_frame_reg <= next_frame_reg + 9'd1;
            end
            if (s1_adv)
            begin
                sum_faults_reg <= sum_faults_new;
                sum_refs_reg   <= sum_refs_new;
            end
            if (s1_adv && upd.set_oom)
            begin
                oom_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Response register: load on advance, drop on transfer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_req_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !req_ready
    ) else $error("request accepted during clearing pass");

    a_no_update_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !s1_vld_reg
    ) else $error("update stage busy during clearing pass");

    a_oom_sticky: assert property (
        @(posedge clk) disable iff (!rst_n) oom_reg |=> oom_reg
    ) else $error("out-of-memory flag cleared without reset");

    a_fault_not_rejected: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_reg.page_fault) |-> !rsp_reg.out_of_memory
    ) else $error("response both faulted and rejected");

endmodule

>>> rtl/dpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read sees the old data.
// ----------------------------------------------------------------------------
module dpt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dpt_clear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_clear: post-reset clearing sequencer
// Sweep every table address once, one per cycle, then drop busy.
// ----------------------------------------------------------------------------
module dpt_clear #(
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    output logic          busy,
    output logic [AW-1:0] addr
);

    logic          busy_reg;
    logic [AW-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
            if (addr_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

>>> rtl/dpt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_update: per-reference decision and counter update
// Classify a reference as ignored, rejected, hit or fault; form new state.
// ----------------------------------------------------------------------------
module dpt_update #(
    parameter int NUM_FRAMES = 256
) (
    input  logic               in_range,
    input  dpt_pkg::dpt_entry_t entry,
    input  dpt_pkg::dpt_pcnt_t pcnt,
    input  logic [8:0]         next_frame,
    input  logic               exhausted,
    input  logic [8:0]         sum_faults,
    input  logic [15:0]        sum_refs,
    output dpt_pkg::dpt_entry_t entry_new,
    output dpt_pkg::dpt_pcnt_t pcnt_new,
    output dpt_pkg::dpt_upd_t  upd,
    output logic [8:0]         sum_faults_new,
    output logic [15:0]        sum_refs_new,
    output dpt_pkg::dpt_rsp_t  rsp
);
    import dpt_pkg::*;

    logic [7:0]  refs_inc;
    logic [7:0]  pfault_inc;
    logic [15:0] prefs_inc;
    logic [8:0]  sfault_inc;
    logic [15:0] srefs_inc;
    logic        no_frame;

    assign refs_inc   = (entry.refs == REFS_MAX) ? entry.refs : entry.refs + 8'd1;
    assign pfault_inc = (pcnt.faults == PFAULT_MAX) ? pcnt.faults : pcnt.faults + 8'd1;
    assign prefs_inc  = (pcnt.refs == COUNT16_MAX) ? pcnt.refs : pcnt.refs + 16'd1;
    assign sfault_inc = (sum_faults == SFAULT_MAX) ? sum_faults : sum_faults + 9'd1;
    assign srefs_inc  = (sum_refs == COUNT16_MAX) ? sum_refs : sum_refs + 16'd1;
    assign no_frame   = (next_frame >= 9'(NUM_FRAMES));

    always_comb
    begin
        entry_new      = entry;
        pcnt_new       = pcnt;
        upd            = '0;
        sum_faults_new = sum_faults;
        sum_refs_new   = sum_refs;
        rsp            = '0;

        rsp.process_fault_count     = pcnt.faults;
        rsp.process_reference_count = pcnt.refs;
        rsp.total_fault_count       = sum_faults;
        rsp.total_reference_count   = sum_refs;

        if (!in_range)
        begin
            rsp = '0;
        end
        else if (exhausted)
        begin
            rsp.out_of_memory = 1'b1;
        end
        else if (entry.valid)
        begin
            entry_new.refs   = refs_inc;
            pcnt_new.refs    = prefs_inc;
            sum_refs_new     = srefs_inc;
            upd.commit_entry = 1'b1;
            upd.commit_proc  = 1'b1;

            rsp.frame_number            = entry.frame;
            rsp.page_ref_count          = refs_inc;
            rsp.process_reference_count = prefs_inc;
            rsp.total_reference_count   = srefs_inc;
        end
        else if (no_frame)
        begin
            upd.set_oom       = 1'b1;
            rsp.out_of_memory = 1'b1;
        end
        else
        begin
            entry_new.valid  = 1'b1;
            entry_new.frame  = next_frame[7:0];
            entry_new.refs   = 8'd1;
            pcnt_new.faults  = pfault_inc;
            pcnt_new.refs    = prefs_inc;
            sum_faults_new   = sfault_inc;
            sum_refs_new     = srefs_inc;
            upd.commit_entry = 1'b1;
            upd.commit_proc  = 1'b1;
            upd.take_frame   = 1'b1;

            rsp.frame_number            = next_frame[7:0];
            rsp.page_fault              = 1'b1;
            rsp.page_ref_count          = 8'd1;
            rsp.process_fault_count     = pfault_inc;
            rsp.process_reference_count = prefs_inc;
            rsp.total_fault_count       = sfault_inc;
            rsp.total_reference_count   = srefs_inc;
        end
    end

endmodule

>>> bench/tb_demand_paging_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_demand_paging_table: self-checking bench for the demand paging table
// Drives (process, page) references through the request channel and checks
// every response field against a cycle-free translation model kept here.
// Covers hits, faults, back-to-back references to one entry, the per-entry
// count saturating, several first_free_frame settings and the sticky
// out-of-memory state, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_demand_paging_table;

    import dpt_pkg::*;

    localparam int NUM_PROCS    = NUM_PROCESSES_DEF;
    localparam int NUM_PAGES    = PAGES_PER_PROCESS_DEF;
    localparam int NUM_SLOTS    = NUM_PROCS * NUM_PAGES;
    localparam int DRAIN_CYCLES = 8;        // response comes from the register behind the update stage
    localparam int CYCLE_LIMIT  = 400000;   // clearing pass plus slowest legal run, many times over
    localparam int PRINT_LIMIT  = 40;       // print this many mismatches, count the rest
    localparam int HOLD_AFTER   = 120;      // references accepted before the long receiver hold
    localparam int HOLD_CYCLES  = 64;

    // ------------------------------------------------------------------
    // DUT connections, all known from time zero
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    dpt_req_t   req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    dpt_rsp_t   rsp;
    logic       cfg_we    = 1'b0;
    logic [8:0] cfg_wdata = '0;

    demand_paging_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Translation model: page tables, frame allocator, counters
    // ------------------------------------------------------------------
    bit         map_valid [NUM_SLOTS];
    bit [7:0]   map_frame [NUM_SLOTS];
    bit [7:0]   map_refs  [NUM_SLOTS];
    bit [8:0]   next_free = FIRST_FREE_RESET;
    bit [7:0]   proc_fault_tally [NUM_PROCS];
    bit [15:0]  proc_ref_tally   [NUM_PROCS];
    bit [8:0]   all_faults;
    bit [15:0]  all_refs;
    bit         frames_gone;

    // Bench bookkeeping
    dpt_req_t   pending_refs [$];   // references not yet offered
    dpt_req_t   recent_refs  [$];   // working set, reused to produce hits
    dpt_rsp_t   expected_rsps [$];  // translations awaiting their response
    int         refs_queued;
    int         refs_accepted;
    int         rsps_checked;
    int         mismatches;
    int         faults_seen;
    int         hits_seen;
    int         rejects_seen;
    int         cfg_writes;
    int         cycles;
    logic       req_fire = 1'b0;
    logic       rsp_fire = 1'b0;
    int         req_gap;
    int         send_quiet;
    int         rsp_stall;
    int         recv_quiet;
    int         long_hold_left;
    bit         long_hold_done;

    // Apply one reference to the model and return the response it must produce.
    function automatic dpt_rsp_t translate_ref(dpt_req_t r);
        dpt_rsp_t res;
        int       pid;
        int       slot;
        bit       counted;
        res     = '0;
        counted = 1'b0;
        pid     = int'(r.process_id);
        // Out-of-range process or page: all zero, no state change
        if (pid >= NUM_PROCS || int'(r.virtual_page) >= NUM_PAGES)
            return res;
        slot = pid * NUM_PAGES + int'(r.virtual_page);
        if (!frames_gone) begin
            if (map_valid[slot]) begin
                if (map_refs[slot] != REFS_MAX)
                    map_refs[slot] = map_refs[slot] + 8'd1;
                res.frame_number   = map_frame[slot];
                res.page_ref_count = map_refs[slot];
                counted            = 1'b1;
            end else if (int'(next_free) >= NUM_FRAMES_DEF) begin
                // No frame left: latch the exhausted state for good
                frames_gone = 1'b1;
            end else begin
                map_valid[slot]    = 1'b1;
                map_frame[slot]    = next_free[7:0];
                map_refs[slot]     = 8'd1;
                next_free          = next_free + 9'd1;
                res.frame_number   = map_frame[slot];
                res.page_ref_count = 8'd1;
                res.page_fault     = 1'b1;
                counted            = 1'b1;
                if (proc_fault_tally[pid] != PFAULT_MAX)
                    proc_fault_tally[pid] = proc_fault_tally[pid] + 8'd1;
                if (all_faults != SFAULT_MAX)
                    all_faults = all_faults + 9'd1;
            end
        end
        if (counted) begin
            if (proc_ref_tally[pid] != COUNT16_MAX)
                proc_ref_tally[pid] = proc_ref_tally[pid] + 16'd1;
            if (all_refs != COUNT16_MAX)
                all_refs = all_refs + 16'd1;
        end
        res.out_of_memory           = frames_gone;
        res.process_fault_count     = proc_fault_tally[pid];
        res.process_reference_count = proc_ref_tally[pid];
        res.total_fault_count       = all_faults;
        res.total_reference_count   = all_refs;
        return res;
    endfunction

    // Idle length between transfers: mostly none or short, now and then long,
    // with stretches of back-to-back transfers.
    function automatic int draw_gap(inout int quiet_left);
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s (response %0d): got %0h, expected %0h",
                     $time, what, rsps_checked, got, want);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_ref(input logic [4:0] pid, input logic [5:0] page);
        dpt_req_t r;
        r.process_id   = pid;
        r.virtual_page = page;
        pending_refs.push_back(r);
        recent_refs.push_back(r);
        if (recent_refs.size() > 12)
            void'(recent_refs.pop_front());
        refs_queued++;
    endtask

    // Mostly revisit the working set (hits), sometimes a new page of a recent
    // process, otherwise anything at all.
    task automatic queue_random_ref();
        dpt_req_t pick;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 60 && recent_refs.size() > 0) begin
            pick = recent_refs[$urandom_range(0, recent_refs.size() - 1)];
        end else if (roll < 72 && recent_refs.size() > 0) begin
            pick              = recent_refs[$];
            pick.virtual_page = 6'($urandom);
        end else begin
            pick.process_id   = 5'($urandom);
            pick.virtual_page = 6'($urandom);
        end
        queue_ref(pick.process_id, pick.virtual_page);
    endtask

    // Block until every queued reference has transferred, every response has
    // come back and the block takes requests; then let the pipe drain.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (refs_accepted != refs_queued || expected_rsps.size() != 0 || !req_ready);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write first_free_frame while idle; the allocator restarts from it.
    task automatic load_first_free(input logic [8:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        next_free  = value;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge only. Hold valid and
    // payload until the transfer; then idle for the drawn gap or offer the
    // next pending reference.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_fire)) begin
            if (req_gap > 0) begin
                req_valid <= 1'b0;
                req_gap--;
            end else if (pending_refs.size() > 0) begin
                req       <= pending_refs.pop_front();
                req_valid <= 1'b1;
                req_gap    = draw_gap(send_quiet);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response ready: random stalls after transfers, plus one long hold once
    // enough references have gone in, so the pipe backs up into req_ready.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else if (!long_hold_done && refs_accepted >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = HOLD_CYCLES - 1;
            rsp_ready     <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_fire)
                rsp_stall = draw_gap(recv_quiet);
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check the response
    // first, then translate the newly transferred request.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        dpt_rsp_t want;
        req_fire <= req_valid && req_ready;
        rsp_fire <= rsp_valid && rsp_ready;
        if (rst_n) begin
            if (rsp_valid && rsp_ready) begin
                rsps_checked++;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("response with nothing outstanding", 16'd0, 16'd0);
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("frame_number", rsp.frame_number, want.frame_number);
                    check_field("page_fault", rsp.page_fault, want.page_fault);
                    check_field("out_of_memory", rsp.out_of_memory, want.out_of_memory);
                    check_field("page_ref_count", rsp.page_ref_count, want.page_ref_count);
                    check_field("process_fault_count", rsp.process_fault_count,
                                want.process_fault_count);
                    check_field("process_reference_count", rsp.process_reference_count,
                                want.process_reference_count);
                    check_field("total_fault_count", rsp.total_fault_count,
                                want.total_fault_count);
                    check_field("total_reference_count", rsp.total_reference_count,
                                want.total_reference_count);
                    if (want.out_of_memory)
                        rejects_seen++;
                    else if (want.page_fault)
                        faults_seen++;
                    else
                        hits_seen++;
                end
            end
            if (req_valid && req_ready) begin
                refs_accepted++;
                expected_rsps.push_back(translate_ref(req));
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("demand_paging_table regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int       i;
        int       phase;
        int       slot;
        dpt_req_t fresh;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, register at its reset value: first fault, back-to-back
        // hits on one entry, the corner process/page, alternating bit patterns.
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd31, 6'd63);
        queue_ref(5'd31, 6'd63);
        queue_ref(5'd0, 6'd63);
        queue_ref(5'd31, 6'd0);
        queue_ref(5'd21, 6'd42);
        queue_ref(5'd10, 6'd21);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd21, 6'd42);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd21, 6'd42);

        // Lowest setting: allocation starts at frame zero
        load_first_free(9'd0);
        queue_ref(5'd5, 6'd5);
        queue_ref(5'd5, 6'd5);
        queue_ref(5'd5, 6'd6);

        // Last frame: one fault takes frame 255, then only hits
        load_first_free(9'd255);
        queue_ref(5'd6, 6'd6);
        queue_ref(5'd6, 6'd6);

        // All ones while only hitting: mappings keep working, no fault taken
        load_first_free(9'd511);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd31, 6'd63);
        queue_ref(5'd6, 6'd6);

        // Random phases; each stays clear of running out of frames
        for (phase = 0; phase < 4; phase++) begin
            load_first_free(9'($urandom_range(0, 170)));
            repeat (80) queue_random_ref();
        end

        // Hot page: enough hits to saturate its count, with some noise mixed in
        load_first_free(9'($urandom_range(0, 200)));
        queue_ref(5'd7, 6'd33);
        for (i = 1; i < 300; i++) begin
            if (i % 10 == 9)
                queue_random_ref();
            else
                queue_ref(5'd7, 6'd33);
        end

        // Highest setting: hits still served until the first fault, which
        // exhausts memory; after that every reference is rejected.
        load_first_free(9'd256);
        queue_ref(5'd0, 6'd0);
        queue_ref(5'd31, 6'd63);
        fresh = '0;
        for (slot = 0; slot < NUM_SLOTS; slot++) begin
            if (!map_valid[slot]) begin
                fresh.process_id   = 5'(slot / NUM_PAGES);
                fresh.virtual_page = 6'(slot % NUM_PAGES);
                break;
            end
        end
        queue_ref(fresh.process_id, fresh.virtual_page);
        queue_ref(5'd0, 6'd0);
        repeat (25) queue_random_ref();

        wait_idle();
        if (expected_rsps.size() != 0)
            report_mismatch("responses never delivered", 16'(expected_rsps.size()), 16'd0);
        $display("covered %0d references over %0d register writes: %0d faults, %0d hits,",
                 refs_accepted, cfg_writes, faults_seen, hits_seen);
        $display("%0d rejected after frames ran out; %0d mismatches in %0d cycles",
                 rejects_seen, mismatches, cycles);
        if (mismatches == 0)
            $display("demand_paging_table regression: pass");
        else
            $display("demand_paging_table regression: fail");
        $finish;
    end

endmodule

>>> demand_paging_table.f
rtl/dpt_pkg.sv
rtl/dpt_ram.sv
rtl/dpt_clear.sv
rtl/dpt_update.sv
rtl/demand_paging_table.sv
bench/tb_demand_paging_table.sv
